// ===== design/distinct_value_set_table_macros.svh =====
// assertion macros shared by the set table rtl
`ifndef DISTINCT_VALUE_SET_TABLE_MACROS_SVH
`define DISTINCT_VALUE_SET_TABLE_MACROS_SVH

// same-cycle implication, disabled during reset
`define DVST_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define DVST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/dvst_pkg.sv =====
// types and constants for the distinct value set table
`default_nettype none
package dvst_pkg;

   localparam int CAPACITY = 16;
   localparam int DATA_W = 32;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int POS_OUT_W = 5;
   localparam int CNT_OUT_W = 5;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_REMOVE = 2'd1,
      OP_SEARCH = 2'd2
   } dvst_op_type;

   typedef enum logic [1:0] {
      ST_DONE = 2'd0,
      ST_PRESENT = 2'd1,
      ST_ABSENT = 2'd2,
      ST_FULL = 2'd3
   } dvst_status_type;

   typedef struct packed {
      dvst_op_type op;
      logic signed [DATA_W-1:0] value;
   } dvst_req_type;

   typedef struct packed {
      logic signed [POS_OUT_W-1:0] position;
      dvst_status_type status;
      logic [CNT_OUT_W-1:0] count;
   } dvst_rsp_type;

   // per-cell update controls
   typedef struct packed {
      logic load_key;
      logic take_next;
   } dvst_cell_ctl_type;

endpackage
`default_nettype wire

// ===== design/dvst_cell.sv =====
// one storage cell of the set table chain
`default_nettype none
module dvst_cell (
   input  logic clock,
   input  logic in_use,
   input  logic signed [dvst_pkg::DATA_W-1:0] key,
   input  logic signed [dvst_pkg::DATA_W-1:0] next_value,
   input  logic hit_before,
   input  dvst_pkg::dvst_cell_ctl_type ctl,
   output logic hit,
   output logic hit_through,
   output logic signed [dvst_pkg::DATA_W-1:0] value_out
);
   import dvst_pkg::*;

   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] value_in;

   assign hit = in_use && (value_ff == key);
   // set when this cell or any cell below it holds the key
   assign hit_through = hit_before || hit;
   assign value_out = value_ff;

   always_comb begin
      value_in = value_ff;
      if (ctl.load_key) begin
         value_in = key;
      end else if (ctl.take_next) begin
         value_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule
`default_nettype wire

// ===== design/distinct_value_set_table.sv =====
// top level of the distinct value set table
//
// A set of up to CAPACITY distinct signed 32-bit values held in insertion
// order, one value per cell in a chain of cells. A request (op, value) is
// transferred at a rising edge where start is high and busy is low; busy
// stays low, so a request may be transferred at every edge. All cells
// compare the value at once in the transfer cycle and update in the same
// edge: add writes the cell at the current count, remove makes every cell
// from the hit position up take its upper neighbor's value.
// Each request gives one result (position found, status, count after the
// request) on rsp_data with rsp_valid high for exactly one cycle, the cycle
// after the transfer. Throughput is one request per cycle.
// The receiver cannot stall: a result is taken in its cycle.
// Synchronous reset empties the set (count zero); cell contents are not
// cleared and are never looked at until written.
`default_nettype none
`include "distinct_value_set_table_macros.svh"
module distinct_value_set_table (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  dvst_pkg::dvst_req_type req_data,
   output logic rsp_valid,
   output dvst_pkg::dvst_rsp_type rsp_data
);
   import dvst_pkg::*;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic rsp_valid_ff;
   dvst_rsp_type rsp_data_ff;
   dvst_rsp_type rsp_data_in;

   logic accept;
   logic found;
   logic full;
   logic [CNT_W-1:0] hit_index;
   logic [CAPACITY-1:0] in_use;
   logic [CAPACITY-1:0] hit;
   logic [CAPACITY-1:0] hit_through;
   logic [CAPACITY-1:0] hit_before;
   logic signed [DATA_W-1:0] cell_value [CAPACITY];
   logic signed [DATA_W-1:0] next_value [CAPACITY];
   dvst_cell_ctl_type cell_ctl [CAPACITY];
   dvst_status_type status;
   logic do_add;
   logic do_remove;

   assign busy = 1'b0;
   assign accept = start && !busy;

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         assign in_use[g] = CNT_W'(g) < count_ff;
         if (g == 0) begin : g_first
            assign hit_before[g] = 1'b0;
         end else begin : g_rest
            assign hit_before[g] = hit_through[g-1];
         end
         if (g == CAPACITY - 1) begin : g_last
            assign next_value[g] = '0;
         end else begin : g_inner
            assign next_value[g] = cell_value[g+1];
         end

         assign cell_ctl[g].load_key = do_add && (count_ff == CNT_W'(g));
         assign cell_ctl[g].take_next = do_remove && hit_through[g]
            && (CNT_W'(g + 1) < count_ff);

         dvst_cell u_cell (
            .clock       (clock),
            .in_use      (in_use[g]),
            .key         (req_data.value),
            .next_value  (next_value[g]),
            .hit_before  (hit_before[g]),
            .ctl         (cell_ctl[g]),
            .hit         (hit[g]),
            .hit_through (hit_through[g]),
            .value_out   (cell_value[g])
         );
      end
   endgenerate

   assign found = hit_through[CAPACITY-1];
   assign full = count_ff >= CNT_W'(CAPACITY);

   // stored values are distinct, so at most one hit and an or-encode suffices
   always_comb begin
      hit_index = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (hit[i]) begin
            hit_index = hit_index | CNT_W'(i);
         end
      end
   end

   always_comb begin
      do_add = 1'b0;
      do_remove = 1'b0;
      count_in = count_ff;
      status = found ? ST_DONE : ST_ABSENT;
      case (req_data.op)
         OP_ADD: begin
            if (found) begin
               status = ST_PRESENT;
            end else if (full) begin
               status = ST_FULL;
            end else begin
               status = ST_DONE;
               do_add = accept;
               if (accept) begin
                  count_in = count_ff + 1'b1;
               end
            end
         end
         OP_REMOVE: begin
            if (found) begin
               do_remove = accept;
               if (accept) begin
                  count_in = count_ff - 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_data_in.position = found ? POS_OUT_W'(hit_index) : '1;
      rsp_data_in.status = status;
      rsp_data_in.count = CNT_OUT_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   `DVST_ASSERT_NOW(a_single_hit, clock, reset, 1'b1, $onehot0(hit),
      "more than one cell matched the key")
   `DVST_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY),
      "entry count above capacity")
   `DVST_ASSERT_NEXT(a_rsp_follows, clock, reset, accept, rsp_valid,
      "transfer without a result in the next cycle")
   `DVST_ASSERT_NEXT(a_add_grows, clock, reset,
      accept && (req_data.op == OP_ADD) && !found && !full,
      count_ff == $past(count_ff) + 1'b1, "add of a new value did not grow the count")
   `DVST_ASSERT_NEXT(a_remove_shrinks, clock, reset,
      accept && (req_data.op == OP_REMOVE) && found,
      (count_ff == $past(count_ff) - 1'b1) && (rsp_data.status == ST_DONE),
      "remove of a present value did not shrink the count")

endmodule
`default_nettype wire
